// ----- src/terminal_line_formatter_assert.svh -----
// assertion macros for the terminal line formatter checker
`ifndef TERMINAL_LINE_FORMATTER_ASSERT_SVH
`define TERMINAL_LINE_FORMATTER_ASSERT_SVH

// same-cycle implication, ignored while reset is asserted
`define TLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while reset is asserted
`define TLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tlf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tlf_pkg;

  // tab stops sit at multiples of a power of two
  localparam int TAB_SHIFT = 3;
  localparam int TAB_STOP  = 1 << TAB_SHIFT;

  localparam logic [7:0] WIDTH_RESET = 8'd80;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_FF       = 8'h0c;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_CARET    = 8'h5e;
  localparam logic [7:0] CH_DEL      = 8'h7f;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;
  localparam logic [7:0] CARET_FLIP  = 8'h40;
  localparam logic [7:0] CH_NULL     = 8'h00;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_PAGE = 1'b1;

  // body operation of one queued transaction
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_CRLF   = 3'd1;
  localparam logic [2:0] OP_FF     = 3'd2;
  localparam logic [2:0] OP_SPACES = 3'd3;
  localparam logic [2:0] OP_CARET  = 3'd4;
  localparam logic [2:0] OP_CHAR   = 3'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic       wrap;   // emit CR LF before the body
    logic [2:0] op;
    logic [7:0] ch;     // byte for caret or plain character
    logic [7:0] col;    // column at start of body
    logic [7:0] stop;   // final column of a space run
  } desc_t;

endpackage

`default_nettype wire

// ----- src/tlf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tlf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_line_width,
  input  wire logic          q_full,
  output logic               q_push,
  output tlf_pkg::desc_t     q_desc
);

  logic [7:0] width_r;
  logic [7:0] col_r, col_nxt;
  logic       skip_r, skip_nxt;

  logic       accept;
  logic       is_nl;
  logic       lazy;
  logic [7:0] c0;
  logic [8:0] tab_nt;
  logic       caret_wrap;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_full;

  always_comb begin
    is_nl  = (in_byte == tlf_pkg::CH_LF) || (in_byte == tlf_pkg::CH_CR);
    lazy   = (col_r >= width_r);
    c0     = lazy ? 8'd0 : col_r;
    tab_nt = {1'b0, (c0 >> tlf_pkg::TAB_SHIFT) << tlf_pkg::TAB_SHIFT}
             + 9'(tlf_pkg::TAB_STOP);
    caret_wrap = (({1'b0, c0} + 9'd2) > {1'b0, width_r}) && (c0 != 8'd0);

    q_desc      = '0;
    q_desc.wrap = lazy;
    q_desc.ch   = in_byte;
    q_desc.col  = c0;
    col_nxt     = col_r;
    skip_nxt    = skip_r;
    q_push      = 1'b0;

    if (accept) begin
      skip_nxt = (in_byte == tlf_pkg::CH_FF);
      // newline right after a formfeed vanishes
      q_push   = !(skip_r && is_nl);
      if (is_nl) begin
        if (!skip_r) begin
          q_desc.wrap = 1'b1;
          q_desc.op   = tlf_pkg::OP_NONE;
          col_nxt     = 8'd0;
        end
      end else if (in_byte == tlf_pkg::CH_FF) begin
        q_desc.op = tlf_pkg::OP_FF;
        col_nxt   = 8'd0;
      end else if (in_byte == tlf_pkg::CH_TAB) begin
        if (tab_nt >= {1'b0, width_r}) begin
          q_desc.op = tlf_pkg::OP_CRLF;
          col_nxt   = 8'd0;
        end else begin
          q_desc.op   = tlf_pkg::OP_SPACES;
          q_desc.stop = tab_nt[7:0];
          col_nxt     = tab_nt[7:0];
        end
      end else if ((in_byte < tlf_pkg::CTRL_LIMIT) || (in_byte == tlf_pkg::CH_DEL)) begin
        q_desc.op = tlf_pkg::OP_CARET;
        if (caret_wrap) begin
          q_desc.wrap = 1'b1;
          q_desc.col  = 8'd0;
          col_nxt     = 8'd2;
        end else begin
          col_nxt = c0 + 8'd2;
        end
      end else begin
        q_desc.op = tlf_pkg::OP_CHAR;
        col_nxt   = c0 + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= tlf_pkg::WIDTH_RESET;
      col_r   <= 8'd0;
      skip_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        width_r <= cfg_line_width;
      end
      col_r  <= col_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/tlf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tlf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tlf_pkg::desc_t push_desc,
  input  wire logic           pop,
  output tlf_pkg::desc_t      head,
  output logic                empty,
  output logic                full
);

  tlf_pkg::desc_t                 mem_r [tlf_pkg::QUEUE_DEPTH];
  logic [tlf_pkg::QPTR_W-1:0]     wr_r, rd_r;
  logic [tlf_pkg::QCNT_W-1:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == tlf_pkg::QCNT_W'(tlf_pkg::QUEUE_DEPTH));
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/tlf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tlf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlf_pkg::desc_t head,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_char,
  output logic                out_kind,
  output logic [7:0]          out_column,
  output logic                out_last
);

  localparam logic [1:0] ST_CR = 2'd0;
  localparam logic [1:0] ST_LF = 2'd1;
  localparam logic [1:0] ST_B0 = 2'd2;
  localparam logic [1:0] ST_B1 = 2'd3;

  tlf_pkg::desc_t desc_r;
  logic [1:0]     state_r, state_nxt;
  logic [7:0]     col_r, col_nxt;
  logic           busy_r;
  logic           out_valid_r;

  logic [7:0]     r_char;
  logic           r_kind;
  logic [7:0]     r_col;
  logic           r_last;
  logic           adv, emit, load;

  assign adv   = !out_valid_r || !out_stall;
  assign emit  = busy_r && adv;
  assign load  = !q_empty && (!busy_r || (emit && r_last));
  assign q_pop = load;
  assign out_valid = out_valid_r;

  always_comb begin
    r_char    = tlf_pkg::CH_CR;
    r_kind    = tlf_pkg::KIND_CHAR;
    r_col     = 8'd0;
    r_last    = 1'b0;
    state_nxt = state_r;
    col_nxt   = col_r;
    unique case (state_r)
      ST_CR: begin
        state_nxt = ST_LF;
      end
      ST_LF: begin
        r_char    = tlf_pkg::CH_LF;
        r_last    = (desc_r.op == tlf_pkg::OP_NONE);
        state_nxt = ST_B0;
      end
      ST_B0: begin
        unique case (desc_r.op)
          tlf_pkg::OP_CRLF: begin
            state_nxt = ST_B1;
          end
          tlf_pkg::OP_FF: begin
            r_char = tlf_pkg::CH_NULL;
            r_kind = tlf_pkg::KIND_PAGE;
            r_last = 1'b1;
          end
          tlf_pkg::OP_SPACES: begin
            r_char  = tlf_pkg::CH_SPACE;
            r_col   = col_r + 8'd1;
            col_nxt = col_r + 8'd1;
            r_last  = ((col_r + 8'd1) == desc_r.stop);
          end
          tlf_pkg::OP_CARET: begin
            r_char    = tlf_pkg::CH_CARET;
            r_col     = col_r + 8'd1;
            col_nxt   = col_r + 8'd1;
            state_nxt = ST_B1;
          end
          tlf_pkg::OP_CHAR: begin
            r_char = desc_r.ch;
            r_col  = col_r + 8'd1;
            r_last = 1'b1;
          end
          default: begin
            r_last = 1'b1;
          end
        endcase
      end
      ST_B1: begin
        if (desc_r.op == tlf_pkg::OP_CRLF) begin
          r_char = tlf_pkg::CH_LF;
        end else begin
          // second half of a caret pair
          r_char = desc_r.ch ^ tlf_pkg::CARET_FLIP;
          r_col  = col_r + 8'd1;
        end
        r_last = 1'b1;
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      state_r     <= ST_CR;
      col_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r  <= 1'b1;
        state_r <= head.wrap ? ST_CR : ST_B0;
        col_r   <= head.col;
      end else if (emit) begin
        if (r_last) begin
          busy_r <= 1'b0;
        end else begin
          state_r <= state_nxt;
          col_r   <= col_nxt;
        end
      end
      if (adv) begin
        out_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= head;
    end
    if (emit) begin
      out_char   <= r_char;
      out_kind   <= r_kind;
      out_column <= r_col;
      out_last   <= r_last;
    end
  end

endmodule

`default_nettype wire

// ----- src/terminal_line_formatter.sv -----
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   in_byte
// out_      output     out_valid/out_stall out_char, out_kind, out_column, out_last
// cfg_      input      cfg_valid/cfg_ready cfg_line_width
//
// the front takes one byte per cycle while the 4-entry queue has room
// the back emits one result per cycle unless out_stall holds it; a queued byte gives 1 to 10 results
// a newline swallowed after a formfeed is still taken by the front and gives no result
// synchronous active-low reset; line width returns to 80, column and formfeed flag clear
// output register lets the back keep working until out_stall holds a waiting result
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_formatter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_kind,
  output logic [7:0]      out_column,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_line_width
);

  tlf_pkg::desc_t push_desc;
  tlf_pkg::desc_t head;
  logic           push, pop, q_empty, q_full;

  tlf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_width (cfg_line_width),
    .q_full         (q_full),
    .q_push         (push),
    .q_desc         (push_desc)
  );

  tlf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tlf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_kind   (out_kind),
    .out_column (out_column),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

// ----- src/tlf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "terminal_line_formatter_assert.svh"

module tlf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_kind,
  input wire logic [7:0] out_column,
  input wire logic       out_last
);

  logic        page_out, page_ok, cr_out;
  logic        caret_lead, caret_tail, out_held;
  logic [7:0]  col_prev_r;
  logic [17:0] out_bits;

  assign page_out   = out_valid && (out_kind == tlf_pkg::KIND_PAGE);
  assign page_ok    = (out_char == tlf_pkg::CH_NULL) && (out_column == 8'd0) && out_last;
  assign cr_out     = out_valid && (out_kind == tlf_pkg::KIND_CHAR)
                      && (out_char == tlf_pkg::CH_CR);
  assign caret_lead = out_valid && !out_stall && (out_kind == tlf_pkg::KIND_CHAR)
                      && (out_char == tlf_pkg::CH_CARET) && !out_last;
  assign caret_tail = out_valid && out_last && (out_column == col_prev_r + 8'd1);
  assign out_held   = out_valid && out_stall;
  assign out_bits   = {out_char, out_kind, out_column, out_last};

  always_ff @(posedge clk) begin
    col_prev_r <= out_column;
  end

  // a page break always closes its transaction at column zero
  `TLF_ASSERT_NOW(a_page_break, page_out, page_ok, "page break result malformed")

  // carriage return only comes from a wrap and resets the column
  `TLF_ASSERT_NOW(a_cr_col, cr_out, out_column == 8'd0 && !out_last, "bad carriage return")

  // caret lead is followed at once by its partner one column further
  `TLF_ASSERT_NEXT(a_caret_pair, caret_lead, caret_tail, "caret pair broken")

  `TLF_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_bits), "stalled result moved")

endmodule

bind terminal_line_formatter tlf_checker u_tlf_checker (.*);

`default_nettype wire
